@@ rtl/core/cnlc_pkg.sv @@
`default_nettype none

package cnlc_pkg;

  // Field widths
  localparam int IN_W    = 54;
  localparam int VERD_W  = 2;
  localparam int CNT_W   = 5;
  localparam int PAIR_W  = 7;

  // Longest accepted number, in decimal digits
  localparam int MAX_DIGITS = 16;

  // BCD holding register: 17 digits cover any 54-bit value
  localparam int BCD_DIGITS = 17;
  localparam int BCD_W      = BCD_DIGITS * 4;

  // Double dabble takes two bits per cycle
  localparam int CONV_STEPS = (IN_W + 1) / 2;
  localparam int PAD_W      = CONV_STEPS * 2;

  typedef logic [IN_W-1:0]   card_t;
  typedef logic [VERD_W-1:0] verdict_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [PAIR_W-1:0] pair_t;
  typedef logic [BCD_W-1:0]  bcd_t;

  // Verdict codes
  localparam verdict_t VERDICT_INVALID = 2'd0;
  localparam verdict_t VERDICT_A       = 2'd1;
  localparam verdict_t VERDICT_B       = 2'd2;
  localparam verdict_t VERDICT_C       = 2'd3;

  // Issuer prefixes and lengths
  localparam pair_t  PAIR_A_LO  = 7'd34;
  localparam pair_t  PAIR_A_HI  = 7'd37;
  localparam pair_t  PAIR_B_MIN = 7'd51;
  localparam pair_t  PAIR_B_MAX = 7'd55;
  localparam pair_t  PAIR_C_MIN = 7'd40;
  localparam pair_t  PAIR_C_MAX = 7'd49;
  localparam count_t LEN_A      = 5'd15;
  localparam count_t LEN_B      = 5'd16;
  localparam count_t LEN_C_S    = 5'd13;
  localparam count_t LEN_C_L    = 5'd16;

  // Converter handshake towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/cnlc_in_if.sv @@
`default_nettype none

interface cnlc_in_if;
  import cnlc_pkg::*;

  logic  valid;
  logic  ready;
  card_t card_number;

  modport source (output valid, output card_number, input ready);
  modport sink   (input valid, input card_number, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cnlc_out_if.sv @@
`default_nettype none

interface cnlc_out_if;
  import cnlc_pkg::*;

  logic     valid;
  logic     ready;
  verdict_t verdict;
  logic     checksum_ok;
  count_t   digit_count;
  pair_t    leading_pair;

  modport source (output valid, output verdict, output checksum_ok, output digit_count,
                  output leading_pair, input ready);
  modport sink   (input valid, input verdict, input checksum_ok, input digit_count,
                  input leading_pair, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cnlc_bin2bcd.sv @@
`default_nettype none

// Iterative double dabble, two input bits per cycle.
module cnlc_bin2bcd (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start_i,
  input  wire cnlc_pkg::card_t      value_i,
  output cnlc_pkg::conv_stat_t      stat_o,
  output cnlc_pkg::bcd_t            bcd_o
);
  import cnlc_pkg::*;

  localparam int STEP_W = $clog2(CONV_STEPS);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [PAD_W-1:0]  sh_r, sh_nxt;
  bcd_t              bcd_r, bcd_nxt;

  // add-3 correction then shift in one bit
  function automatic bcd_t dabble(input bcd_t b, input logic b_in);
    bcd_t a;
    a = b;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (a[4*k +: 4] >= 4'd5) begin
        a[4*k +: 4] = a[4*k +: 4] + 4'd3;
      end
    end
    return {a[BCD_W-2:0], b_in};
  endfunction

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    sh_nxt   = sh_r;
    bcd_nxt  = bcd_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      sh_nxt   = PAD_W'(value_i);
      bcd_nxt  = '0;
    end else if (busy_r) begin
      bcd_nxt  = dabble(dabble(bcd_r, sh_r[PAD_W-1]), sh_r[PAD_W-2]);
      sh_nxt   = {sh_r[PAD_W-3:0], 2'b00};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(CONV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
  end

  assign stat_o.busy = busy_r;
  assign stat_o.done = done_r;
  assign bcd_o       = bcd_r;

endmodule

`default_nettype wire

@@ rtl/core/card_number_luhn_classifier.sv @@
// Flow: two-bit-a-cycle double dabble conversion, a copy of the digits, the
//   one-digit-a-cycle Luhn pass, then a finishing step that classifies.
// A new number is accepted only while idle, after the previous one has gone to
//   the output register; the finishing step waits while a result is not taken.
// Reset: synchronous, active low; clears control and valid state, not the datapath.
`default_nettype none

module card_number_luhn_classifier (
  input wire logic clk,
  input wire logic rst_n,
  cnlc_in_if.sink    in_ch,
  cnlc_out_if.source out_ch
);
  import cnlc_pkg::*;

  localparam int IDX_W = $clog2(BCD_DIGITS);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a number
  localparam logic [1:0] ST_CONV = 2'd1;  // binary to BCD running
  localparam logic [1:0] ST_DIGS = 2'd2;  // one digit per cycle, least significant first
  localparam logic [1:0] ST_FIN  = 2'd3;  // classify, hand to output register

  logic [1:0] state_r, state_nxt;

  logic       in_xfer;
  conv_stat_t conv_stat;
  bcd_t       conv_bcd;

  // Digit pass working registers
  bcd_t             dig_sh_r, dig_sh_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [3:0]       sum_r, sum_nxt;   // running Luhn sum, kept mod 10
  count_t           cnt_r, cnt_nxt;
  pair_t            pair_r, pair_nxt;
  logic [3:0]       prev_r, prev_nxt; // digit below the current one

  // Output register
  logic     out_valid_r, out_valid_nxt;
  verdict_t verdict_r, verdict_nxt;
  logic     ok_r, ok_nxt;
  count_t   count_out_r, count_out_nxt;
  pair_t    pair_out_r, pair_out_nxt;

  // Per-digit signals
  logic [3:0] dig;
  logic [4:0] dbl;
  logic [4:0] luhn_add;
  logic [4:0] sum_raw;

  // Finishing signals
  logic   out_free;
  count_t cnt_fix;
  logic   fin_ok;
  verdict_t fin_verdict;

  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;

  cnlc_bin2bcd u_conv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (in_xfer),
    .value_i (in_ch.card_number),
    .stat_o  (conv_stat),
    .bcd_o   (conv_bcd)
  );

  // Luhn contribution of the current digit: odd positions are doubled,
  // a doubled value above nine folds back by subtracting nine.
  always_comb begin
    dig = dig_sh_r[3:0];
    dbl = {dig, 1'b0};
    if (dbl > 5'd9) begin
      dbl = dbl - 5'd9;
    end
    luhn_add = idx_r[0] ? dbl : {1'b0, dig};
    sum_raw  = {1'b0, sum_r} + luhn_add;
  end

  // Classification from the finished digit pass
  always_comb begin
    cnt_fix     = (cnt_r == 5'd1) ? 5'd2 : cnt_r;
    fin_ok      = (sum_r == 4'd0);
    fin_verdict = VERDICT_INVALID;
    if (fin_ok) begin
      if ((pair_r inside {PAIR_A_LO, PAIR_A_HI}) && cnt_fix == LEN_A) begin
        fin_verdict = VERDICT_A;
      end else if ((pair_r inside {[PAIR_B_MIN:PAIR_B_MAX]}) && cnt_fix == LEN_B) begin
        fin_verdict = VERDICT_B;
      end else if ((pair_r inside {[PAIR_C_MIN:PAIR_C_MAX]}) &&
                   (cnt_fix == LEN_C_S || cnt_fix == LEN_C_L)) begin
        fin_verdict = VERDICT_C;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    dig_sh_nxt    = dig_sh_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    pair_nxt      = pair_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r;
    verdict_nxt   = verdict_r;
    ok_nxt        = ok_r;
    count_out_nxt = count_out_r;
    pair_out_nxt  = pair_out_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        // converter finished: take its digits and clear the accumulators
        if (conv_stat.done) begin
          dig_sh_nxt = conv_bcd;
          idx_nxt    = '0;
          sum_nxt    = '0;
          cnt_nxt    = '0;
          pair_nxt   = '0;
          prev_nxt   = '0;
          state_nxt  = ST_DIGS;
        end
      end
      ST_DIGS: begin
        sum_nxt = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
        // the highest nonzero digit seen so far sets count and leading pair
        if (dig != 4'd0) begin
          cnt_nxt = CNT_W'(idx_r) + 1'b1;
          if (idx_r == '0) begin
            pair_nxt = PAIR_W'(dig);
          end else begin
            pair_nxt = PAIR_W'({dig, 3'b000}) + PAIR_W'({dig, 1'b0}) + PAIR_W'(prev_r);
          end
        end
        prev_nxt   = dig;
        dig_sh_nxt = {4'd0, dig_sh_r[BCD_W-1:4]};
        idx_nxt    = idx_r + 1'b1;
        if (idx_r == IDX_W'(BCD_DIGITS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (cnt_r > CNT_W'(MAX_DIGITS)) begin
            // too long for a card: all-zero result
            verdict_nxt   = VERDICT_INVALID;
            ok_nxt        = 1'b0;
            count_out_nxt = '0;
            pair_out_nxt  = '0;
          end else begin
            verdict_nxt   = fin_verdict;
            ok_nxt        = fin_ok;
            count_out_nxt = cnt_fix;
            pair_out_nxt  = pair_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
    dig_sh_r    <= dig_sh_nxt;
    sum_r       <= sum_nxt;
    cnt_r       <= cnt_nxt;
    pair_r      <= pair_nxt;
    prev_r      <= prev_nxt;
    verdict_r   <= verdict_nxt;
    ok_r        <= ok_nxt;
    count_out_r <= count_out_nxt;
    pair_out_r  <= pair_out_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.verdict      = verdict_r;
  assign out_ch.checksum_ok  = ok_r;
  assign out_ch.digit_count  = count_out_r;
  assign out_ch.leading_pair = pair_out_r;

  // An input transfer always starts the converter on the next cycle
  a_xfer_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_CONV && conv_stat.busy))
    else $error("input transfer did not start conversion");

  // Converter completion is only seen while the sequencer waits for it
  a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    conv_stat.done |-> state_r == ST_CONV)
    else $error("converter done outside conversion state");

  // A class verdict implies a passing checksum
  a_verdict_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (verdict_r == VERDICT_INVALID || ok_r))
    else $error("class verdict with failing checksum");

  // One-digit numbers are reported with a count of two
  a_no_count_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> count_out_r != 5'd1)
    else $error("digit count of one reported");

endmodule

`default_nettype wire
